[design/tpc_pkg.sv]
// Shared types, constants and byte classification for the pretokenizer chunker.
`default_nettype none
package tpc_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int OFS_W             = 32;
    localparam int MAX_CHUNKS        = 4;
    localparam int CNT_W             = 3;

    localparam logic [2:0] CLS_LET   = 3'd0;
    localparam logic [2:0] CLS_DIG   = 3'd1;
    localparam logic [2:0] CLS_BLANK = 3'd2;
    localparam logic [2:0] CLS_NL    = 3'd3;
    localparam logic [2:0] CLS_PUN   = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [OFS_W-1:0] chunk_start;
        logic [OFS_W-1:0] chunk_end;
        logic             last_of_item;
        logic             final_chunk;
        logic             position_overflow;
    } t_out_item;

    // All chunks caused by one text byte.
    typedef struct packed {
        logic [MAX_CHUNKS-1:0][OFS_W-1:0] starts;
        logic [MAX_CHUNKS-1:0][OFS_W-1:0] ends;
        logic [CNT_W-1:0]                 count;
        logic                             eot;
        logic                             ovf;
    } t_chunk_cmd;

    function automatic logic [2:0] byte_class(input logic [7:0] c);
        logic [2:0] r;
        if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c[7]) begin
            r = CLS_LET;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = CLS_DIG;
        end else if (c == 8'h0d || c == 8'h0a) begin
            r = CLS_NL;
        end else if (c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c) begin
            r = CLS_BLANK;
        end else begin
            r = CLS_PUN;
        end
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

endpackage
`default_nettype wire

[design/text_pretokenizer_chunker.sv]
// Top level of the streaming pretokenizer chunker.
`default_nettype none
// The block takes one text byte per transaction, with end_of_text on the last
// byte of a text, and returns one transaction per chunk with its start and end
// byte offsets. Splitting follows a cl100k-style regex pretokenizer: contractions,
// an optional prefix byte plus a letter run, single digits, punctuation runs with
// trailing newlines, and the whitespace rules; bytes 0x80 and up count as letters.
// A byte may complete zero to four chunks; last_of_item marks the last one a byte
// caused and final_chunk the last chunk of a text. After end_of_text the next byte
// starts a new text at offset zero. Offsets saturate at 2^POSITION_BITS-1, and
// position_overflow is then set on the rest of that text's chunks; above 32 bits
// only the low 32 bits of each offset are sent. The front end accepts one byte per
// cycle while its four-entry queue has room; the back end sends one chunk per
// cycle while the output is not stalled, and the queue lets new bytes enter while
// a chunk waits in the output register to be taken.
module text_pretokenizer_chunker #(
    parameter int POSITION_BITS = tpc_pkg::POSITION_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  tpc_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output tpc_pkg::t_out_item  o_out_data
);
    import tpc_pkg::*;

    // Front end to queue.
    logic       push, full;
    t_chunk_cmd front_cmd;

    // Queue to back end.
    logic       q_valid, pop;
    t_chunk_cmd head_cmd;

    tpc_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_push  (push),
        .i_full  (full),
        .o_cmd   (front_cmd)
    );

    tpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    tpc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_data    (o_out_data)
    );

endmodule
`default_nettype wire

[design/tpc_front.sv]
// Front end: classifies each text byte and works out the chunks it completes.
`default_nettype none
module tpc_front #(
    parameter int POSITION_BITS = tpc_pkg::POSITION_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  tpc_pkg::t_in_item    i_data,
    output logic                 o_push,
    input  wire                  i_full,
    output tpc_pkg::t_chunk_cmd  o_cmd
);
    import tpc_pkg::*;

    localparam logic [3:0] M_IDLE        = 4'd0;
    localparam logic [3:0] M_LETTERS     = 4'd1;
    localparam logic [3:0] M_PUNCT       = 4'd2;
    localparam logic [3:0] M_PUNCT_NL    = 4'd3;
    localparam logic [3:0] M_AFTER_P     = 4'd4;
    localparam logic [3:0] M_AFTER_SPACE = 4'd5;
    localparam logic [3:0] M_AFTER_APOS  = 4'd6;
    localparam logic [3:0] M_APOS2       = 4'd7;
    localparam logic [3:0] M_WS          = 4'd8;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [3:0]               r_mode, n_mode;
    logic [7:0]               r_hold, n_hold;
    logic [POSITION_BITS-1:0] r_begin, n_begin;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_lastnl, n_lastnl;
    logic                     r_hasnl, n_hasnl;
    logic                     r_ovf, n_ovf;
    logic [1:0]               r_tail, n_tail;

    logic                     accept;
    t_chunk_cmd               cmd;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && (cmd.count != '0);
    assign o_cmd   = cmd;

    always_comb begin
        logic [7:0]               b;
        logic [7:0]               l;
        logic [2:0]               c;
        logic [POSITION_BITS-1:0] p, e, q, x, sx;
        logic                     do_single, do_fresh, join_let, do_punct;
        logic [CNT_W-1:0]         cnt;
        b = i_data.text_byte;
        c = byte_class(b);
        l = to_lower(b);
        n_mode = r_mode; n_hold = r_hold; n_begin = r_begin; n_pos = r_pos;
        n_lastnl = r_lastnl; n_hasnl = r_hasnl; n_ovf = r_ovf; n_tail = r_tail;
        cmd = '0;
        cnt = '0;
        do_single = 1'b0; do_fresh = 1'b0; do_punct = 1'b0; join_let = 1'b0;
        sx = r_begin; q = r_begin; x = r_begin;
        if (r_pos == POS_MAX) begin
            n_ovf = 1'b1; p = POS_MAX; e = POS_MAX;
        end else begin
            p = r_pos; e = r_pos + 1'b1; n_pos = e;
        end

        unique case (r_mode)
            M_LETTERS: begin
                if (c != CLS_LET) begin
                    if (cnt < 3'd4) begin
                        cmd.starts[cnt[1:0]] = OFS_W'(r_begin);
                        cmd.ends[cnt[1:0]] = OFS_W'(p); cnt = cnt + 1'b1;
                    end
                    do_fresh = 1'b1;
                end
            end
            M_PUNCT: do_punct = 1'b1;
            M_AFTER_P: begin
                do_punct = 1'b1; join_let = 1'b1;
            end
            M_PUNCT_NL: begin
                if (c != CLS_NL) begin
                    if (cnt < 3'd4) begin
                        cmd.starts[cnt[1:0]] = OFS_W'(r_begin);
                        cmd.ends[cnt[1:0]] = OFS_W'(p); cnt = cnt + 1'b1;
                    end
                    do_fresh = 1'b1;
                end
            end
            M_AFTER_SPACE: begin
                do_single = 1'b1; sx = r_begin;
            end
            M_AFTER_APOS: begin
                if (l == 8'h73 || l == 8'h74 || l == 8'h6d || l == 8'h64) begin
                    if (cnt < 3'd4) begin
                        cmd.starts[cnt[1:0]] = OFS_W'(r_begin);
                        cmd.ends[cnt[1:0]] = OFS_W'(e); cnt = cnt + 1'b1;
                    end
                    n_mode = M_IDLE;
                end else if (l == 8'h72 || l == 8'h76 || l == 8'h6c) begin
                    n_mode = M_APOS2; n_hold = b;
                end else begin
                    do_punct = 1'b1; join_let = 1'b1;
                end
            end
            M_APOS2: begin
                if ((to_lower(r_hold) == 8'h72 && l == 8'h65) ||
                    (to_lower(r_hold) == 8'h76 && l == 8'h65) ||
                    (to_lower(r_hold) == 8'h6c && l == 8'h6c)) begin
                    if (cnt < 3'd4) begin
                        cmd.starts[cnt[1:0]] = OFS_W'(r_begin);
                        cmd.ends[cnt[1:0]] = OFS_W'(e); cnt = cnt + 1'b1;
                    end
                    n_mode = M_IDLE;
                end else begin
                    n_mode = M_LETTERS;
                    if (c != CLS_LET) begin
                        if (cnt < 3'd4) begin
                            cmd.starts[cnt[1:0]] = OFS_W'(r_begin);
                            cmd.ends[cnt[1:0]] = OFS_W'(p); cnt = cnt + 1'b1;
                        end
                        do_fresh = 1'b1;
                    end
                end
            end
            M_WS: begin
                if (c == CLS_BLANK) begin
                    n_tail = (r_tail < 2'd2) ? r_tail + 1'b1 : 2'd2;
                    n_hold = b;
                end else if (c == CLS_NL) begin
                    n_hasnl = 1'b1; n_lastnl = p; n_tail = 2'd0;
                end else begin
                    q = r_begin;
                    if (r_hasnl) begin
                        q = (r_lastnl == POS_MAX) ? POS_MAX : r_lastnl + 1'b1;
                        if (cnt < 3'd4) begin
                            cmd.starts[cnt[1:0]] = OFS_W'(r_begin);
                            cmd.ends[cnt[1:0]] = OFS_W'(q); cnt = cnt + 1'b1;
                        end
                    end
                    n_hasnl = 1'b0;
                    if (r_tail == 2'd0) begin
                        do_fresh = 1'b1;
                    end else begin
                        x = q;
                        if (r_tail >= 2'd2) begin
                            x = (p == '0) ? '0 : p - 1'b1;
                            if (cnt < 3'd4) begin
                                cmd.starts[cnt[1:0]] = OFS_W'(q);
                                cmd.ends[cnt[1:0]] = OFS_W'(x); cnt = cnt + 1'b1;
                            end
                        end
                        n_tail = 2'd0;
                        do_single = 1'b1; sx = x;
                    end
                end
            end
            default: do_fresh = 1'b1;
        endcase

        // Punctuation run continues, turns into trailing newlines, becomes a letter run after a prefix byte, or closes.
        if (do_punct) begin
            if (c == CLS_PUN) begin
                n_mode = M_PUNCT;
            end else if (c == CLS_NL) begin
                n_mode = M_PUNCT_NL;
            end else if (c == CLS_LET && join_let) begin
                n_mode = M_LETTERS;
            end else begin
                if (cnt < 3'd4) begin
                    cmd.starts[cnt[1:0]] = OFS_W'(r_begin);
                    cmd.ends[cnt[1:0]] = OFS_W'(p); cnt = cnt + 1'b1;
                end
                do_fresh = 1'b1;
            end
        end

        // A single held blank at sx, followed by the current byte.
        if (do_single) begin
            n_begin = sx;
            if (c == CLS_LET) begin
                n_mode = M_LETTERS;
            end else if (c == CLS_PUN && r_hold == 8'h20) begin
                n_mode = M_PUNCT;
            end else if (c == CLS_BLANK || c == CLS_NL) begin
                n_mode = M_WS;
                if (c == CLS_NL) begin
                    n_hasnl = 1'b1; n_lastnl = p; n_tail = 2'd0;
                end else begin
                    n_hasnl = 1'b0; n_tail = 2'd2; n_hold = b;
                end
            end else begin
                if (cnt < 3'd4) begin
                    cmd.starts[cnt[1:0]] = OFS_W'(sx);
                    cmd.ends[cnt[1:0]] = OFS_W'(p); cnt = cnt + 1'b1;
                end
                do_fresh = 1'b1;
            end
        end

        // Start a new chunk at the current byte.
        if (do_fresh) begin
            n_begin = p;
            case (c)
                CLS_LET: n_mode = M_LETTERS;
                CLS_DIG: begin
                    if (cnt < 3'd4) begin
                        cmd.starts[cnt[1:0]] = OFS_W'(p);
                        cmd.ends[cnt[1:0]] = OFS_W'(e); cnt = cnt + 1'b1;
                    end
                    n_mode = M_IDLE;
                end
                CLS_NL: begin
                    n_mode = M_WS; n_hasnl = 1'b1; n_lastnl = p; n_tail = 2'd0;
                end
                CLS_BLANK: begin
                    n_mode = M_AFTER_SPACE; n_hold = b;
                end
                default: n_mode = (b == 8'h27) ? M_AFTER_APOS : M_AFTER_P;
            endcase
        end

        cmd.ovf = n_ovf;
        cmd.eot = i_data.end_of_text;

        // End of text closes whatever is open and returns to the reset state.
        if (i_data.end_of_text) begin
            if (n_mode == M_WS) begin
                if (n_hasnl) begin
                    q = (n_lastnl == POS_MAX) ? POS_MAX : n_lastnl + 1'b1;
                    if (cnt < 3'd4) begin
                        cmd.starts[cnt[1:0]] = OFS_W'(n_begin);
                        cmd.ends[cnt[1:0]] = OFS_W'(q); cnt = cnt + 1'b1;
                    end
                    if (n_tail != 2'd0 && cnt < 3'd4) begin
                        cmd.starts[cnt[1:0]] = OFS_W'(q);
                        cmd.ends[cnt[1:0]] = OFS_W'(e); cnt = cnt + 1'b1;
                    end
                end else if (cnt < 3'd4) begin
                    cmd.starts[cnt[1:0]] = OFS_W'(n_begin);
                    cmd.ends[cnt[1:0]] = OFS_W'(e); cnt = cnt + 1'b1;
                end
            end else if (n_mode != M_IDLE && cnt < 3'd4) begin
                cmd.starts[cnt[1:0]] = OFS_W'(n_begin);
                cmd.ends[cnt[1:0]] = OFS_W'(e); cnt = cnt + 1'b1;
            end
            n_mode = M_IDLE; n_hold = '0; n_begin = '0; n_pos = '0;
            n_lastnl = '0; n_hasnl = 1'b0; n_ovf = 1'b0; n_tail = 2'd0;
        end
        cmd.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_hold <= '0; r_begin <= '0; r_pos <= '0;
            r_lastnl <= '0; r_hasnl <= 1'b0; r_ovf <= 1'b0; r_tail <= 2'd0;
        end else if (accept) begin
            r_mode <= n_mode; r_hold <= n_hold; r_begin <= n_begin; r_pos <= n_pos;
            r_lastnl <= n_lastnl; r_hasnl <= n_hasnl; r_ovf <= n_ovf; r_tail <= n_tail;
        end
    end

endmodule
`default_nettype wire

[design/tpc_queue.sv]
// Short queue of chunk groups between the front end and the output stage.
`default_nettype none
module tpc_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  tpc_pkg::t_chunk_cmd  i_cmd,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_valid,
    output tpc_pkg::t_chunk_cmd  o_cmd
);
    import tpc_pkg::*;

    t_chunk_cmd r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

[design/tpc_back.sv]
// Back end: sends a group's chunks one per cycle unless stalled, through an output register.
`default_nettype none
module tpc_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_q_valid,
    input  tpc_pkg::t_chunk_cmd  i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_stall,
    output tpc_pkg::t_out_item   o_data
);
    import tpc_pkg::*;

    logic       r_valid;
    t_out_item  r_out;
    logic [1:0] r_k;
    logic       load, last;

    assign load    = i_q_valid && (!r_valid || !i_stall);
    assign last    = ({1'b0, r_k} + 3'd1) == i_cmd.count;
    assign o_pop   = load && last;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.chunk_start       <= i_cmd.starts[r_k];
            r_out.chunk_end         <= i_cmd.ends[r_k];
            r_out.last_of_item      <= last;
            r_out.final_chunk       <= last && i_cmd.eot;
            r_out.position_overflow <= i_cmd.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= last ? 2'd0 : r_k + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
